// ----- rtl/aes_pkg.sv -----
`default_nettype none
package aes_pkg;
    localparam int ROUNDS = 14;
    localparam int RK_DEPTH = 30;
    localparam int RK_AW = 5;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd6;

    localparam logic [7:0] SBOX [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // state bytes: byte 0 in bits 127:120
    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] gb(input logic [127:0] s, input int i);
        gb = s[127-8*i -: 8];
    endfunction

    // sub bytes, shift rows, optional mix columns
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0] a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = SBOX[gb(s, (i % 4) + 4 * (((i / 4) + (i % 4)) % 4))];
        for (int c = 0; c < 4; c++)
        begin
            a0 = gb(t, 4*c); a1 = gb(t, 4*c+1); a2 = gb(t, 4*c+2); a3 = gb(t, 4*c+3);
            m[127-32*c -: 8]  = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[119-32*c -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[111-32*c -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[103-32*c -: 8]  = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        enc_round = last ? t : m;
    endfunction

    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i]) p = p ^ x;
            x = xt(x);
        end
        gm = p;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] m;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
            m[127-32*c -: 8] = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
            m[119-32*c -: 8] = gm(a0,4'd9) ^ gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13);
            m[111-32*c -: 8] = gm(a0,4'd13) ^ gm(a1,4'd9) ^ gm(a2,4'd14) ^ gm(a3,4'd11);
            m[103-32*c -: 8] = gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9) ^ gm(a3,4'd14);
        end
        inv_mix = m;
    endfunction

    // inverse shift rows and inverse sub bytes
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127-8*((i % 4) + 4 * (((i / 4) + (i % 4)) % 4)) -: 8] = ISBOX[gb(s, i)];
        dec_sub = t;
    endfunction

    typedef struct packed {
        logic         valid;
        logic         dec;
        logic         last;
        logic [127:0] chain;
        logic [127:0] next_chain_in;
    } aes_tag_t;
endpackage
`default_nettype wire

// ----- rtl/aes256_cbc_block_cipher_core.sv -----
`default_nettype none
// aes-256 cbc core: one 128-bit block per beat, encrypt or decrypt by decrypt_mode.
// a block is taken only while the round unit is idle, since the chain value ties each
// block to the result of the one before. the round key for the initial key add is read
// in the accepting cycle; the round unit then applies the initial key add and the 14
// rounds, one per cycle, and the result lands in the output register. the next block
// can be taken once the result has landed, so one block is in the round unit at a
// time. if the output register still holds an untaken result, the round unit holds
// its last round until the register frees. after any key write the next block waits
// while the core kicks the key schedule and the schedule fills the round key memory
// one 64-bit word per cycle. results sit in an output register, so a new block is
// taken while a result waits. tdata of s_axis: block_high in [63:0], block_low in
// [127:64]; tlast carries last_block. m_axis is packed the same way with result_last
// on tlast.
module aes256_cbc_block_cipher_core
    import aes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // block_high, block_low
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,  // result_high, result_low
    output logic              m_axis_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]  cfg_data
);
    logic [255:0] key_reg;
    logic [127:0] iv_reg;
    logic dec_reg;
    logic [127:0] chain_reg;
    logic start_reg;
    logic expanded_reg;
    logic kick_reg;
    logic ke_busy;
    logic [127:0] rk;
    logic [RK_AW-2:0] rk_addr;
    logic rnd_busy, rnd_done;
    logic [127:0] rnd_state;
    aes_tag_t rnd_tag, ld_tag;
    logic inflight_reg;
    logic out_full_reg;
    logic [127:0] out_data_reg;
    logic out_last_reg;
    logic accept, load;
    logic [127:0] cur_chain, blk, ld_state;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            iv_reg  <= '0;
            dec_reg <= 1'b0;
            expanded_reg <= 1'b0;
            kick_reg <= 1'b0;
        end
        else
        begin
            kick_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_KEY0: key_reg[255:192] <= cfg_data;
                    REG_KEY1: key_reg[191:128] <= cfg_data;
                    REG_KEY2: key_reg[127:64]  <= cfg_data;
                    REG_KEY3: key_reg[63:0]    <= cfg_data;
                    REG_IV_HI: iv_reg[127:64]  <= cfg_data;
                    REG_IV_LO: iv_reg[63:0]    <= cfg_data;
                    REG_MODE: dec_reg          <= cfg_data[0];
                    default: ;
                endcase
                if (cfg_index == REG_KEY0 || cfg_index == REG_KEY1 ||
                    cfg_index == REG_KEY2 || cfg_index == REG_KEY3)
                    expanded_reg <= 1'b0;
            end
            else if (!expanded_reg && !ke_busy && !kick_reg)
            begin
                kick_reg <= 1'b1;
                expanded_reg <= 1'b1;
            end
        end
    end

    aes_key_exp u_kexp (
        .clk(clk), .rst_n(rst_n), .start(kick_reg), .key(key_reg),
        .rd_addr(rk_addr), .rd_data(rk), .busy(ke_busy)
    );

    // one block in the round unit at a time; the chain comes back at its end
    assign s_axis_tready = expanded_reg && !kick_reg && !ke_busy && !inflight_reg &&
                           !(out_full_reg && !m_axis_tready && rnd_busy);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign load = accept;
    assign cur_chain = start_reg ? iv_reg : chain_reg;
    assign blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign ld_state = dec_reg ? blk : (blk ^ cur_chain);
    assign ld_tag = '{valid: 1'b1, dec: dec_reg, last: s_axis_tlast,
                      chain: cur_chain, next_chain_in: blk};

    aes_round u_round (
        .clk(clk), .rst_n(rst_n), .load(load), .load_state(ld_state), .load_tag(ld_tag),
        .rk(rk), .hold(out_full_reg && !m_axis_tready), .rk_addr(rk_addr),
        .done(rnd_done), .done_state(rnd_state), .done_tag(rnd_tag), .busy(rnd_busy)
    );

    // round unit holds its result until the output register frees
    logic [127:0] res;
    assign res = rnd_tag.dec ? (rnd_state ^ rnd_tag.chain) : rnd_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= 1'b1;
            inflight_reg <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                inflight_reg <= 1'b1;
                start_reg    <= s_axis_tlast;
            end
            if (rnd_done) inflight_reg <= 1'b0;
            if (rnd_done) out_full_reg <= 1'b1;
            else if (m_axis_tready) out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) chain_reg <= cur_chain;
        if (rnd_done)
        begin
            out_data_reg <= res;
            out_last_reg <= rnd_tag.last;
            chain_reg    <= rnd_tag.dec ? rnd_tag.next_chain_in : rnd_state;
        end
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata  = {out_data_reg[63:0], out_data_reg[127:64]};
    assign m_axis_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ----- rtl/aes_key_exp.sv -----
`default_nettype none
// expands the key into a synchronous round key memory, one 64-bit word per cycle
module aes_key_exp
    import aes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [255:0] key,
    input  wire logic [RK_AW-2:0] rd_addr,
    output logic [127:0]      rd_data,
    output logic              busy
);
    logic [63:0] mem_lo [RK_DEPTH/2];
    logic [63:0] mem_hi [RK_DEPTH/2];
    logic [255:0] win_reg;
    logic [RK_AW-1:0] cnt_reg;
    logic [7:0] rcon_reg;
    logic busy_reg;
    logic [31:0] t0, w0, w1;
    logic [255:0] win_next;

    // window holds eight words; each step after the first four yields two more
    // step n makes words 2n and 2n+1: rotate and rcon every fourth step, sub word
    // two steps later, plain xor otherwise
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    t0 = sub_word({win_reg[23:0], win_reg[31:24]}) ^ {rcon_reg, 24'h0};
            2'd2:    t0 = sub_word(win_reg[31:0]);
            default: t0 = win_reg[31:0];
        endcase
        w0 = win_reg[255:224] ^ t0;
        w1 = win_reg[223:192] ^ w0;
        win_next = {win_reg[191:0], w0, w1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == RK_AW'(RK_DEPTH - 1)) busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg >= RK_AW'(4) && cnt_reg[1:0] == 2'd0) rcon_reg <= xt(rcon_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) win_reg <= key;
        else if (busy_reg && cnt_reg >= RK_AW'(4)) win_reg <= win_next;
    end

    // even words go to the high bank, odd words to the low bank, so one read
    // gives a full round key
    logic [63:0] wr_word;
    assign wr_word = (cnt_reg < RK_AW'(4)) ? win_reg[255 - 64*cnt_reg[1:0] -: 64] : {w0, w1};

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (!cnt_reg[0]) mem_hi[cnt_reg[RK_AW-1:1]] <= wr_word;
            else mem_lo[cnt_reg[RK_AW-1:1]] <= wr_word;
        end
        rd_data <= {mem_hi[rd_addr], mem_lo[rd_addr]};
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

// ----- rtl/aes_round.sv -----
`default_nettype none
// one round per cycle over a 15-step pass, the last step waiting while hold is set; one block at a time
module aes_round
    import aes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire logic [127:0] load_state,
    input  wire aes_tag_t     load_tag,
    input  wire logic [127:0] rk,
    input  wire logic         hold,
    output logic [RK_AW-2:0]  rk_addr,
    output logic              done,
    output logic [127:0]      done_state,
    output aes_tag_t          done_tag,
    output logic              busy
);
    logic [127:0] st_reg;
    aes_tag_t tag_reg;
    logic [4:0] step_reg;
    logic act_reg;
    logic stall;
    logic [3:0] enc_addr, dec_addr;
    logic [127:0] nxt;

    // the load cycle reads the first round key, steps 1..15 apply rounds 0..14;
    // step 15 keeps reading the last round key so it can wait for the output
    assign stall    = act_reg && step_reg == 5'd15 && hold;
    assign enc_addr = (step_reg == 5'd15) ? 4'd14 : step_reg[3:0];
    assign dec_addr = (step_reg == 5'd15) ? 4'd0 : 4'd14 - step_reg[3:0];
    assign rk_addr  = load ? (load_tag.dec ? 4'd14 : 4'd0)
                           : (tag_reg.dec ? dec_addr : enc_addr);

    always_comb
    begin
        if (step_reg == 5'd1)
            nxt = st_reg ^ rk;
        else if (!tag_reg.dec)
            nxt = enc_round(st_reg, step_reg == 5'd15) ^ rk;
        else if (step_reg == 5'd15)
            nxt = dec_sub(st_reg) ^ rk;
        else
            nxt = inv_mix(dec_sub(st_reg) ^ rk);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (load)
        begin
            act_reg  <= 1'b1;
            step_reg <= 5'd1;
        end
        else if (act_reg && !stall)
        begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'd15) act_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg  <= load_state;
            tag_reg <= load_tag;
        end
        else if (act_reg && !stall)
            st_reg <= nxt;
    end

    assign done       = act_reg && step_reg == 5'd15 && !hold;
    assign done_state = nxt;
    assign done_tag   = tag_reg;
    assign busy       = act_reg && !done;
endmodule
`default_nettype wire

// ----- rtl/aes_checker.sv -----
`default_nettype none
module aes_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tlast,
    input wire logic [127:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))
        else $error("output beat dropped");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second block taken while one in flight");
    a_noout: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result too early");
endmodule
bind aes256_cbc_block_cipher_core aes_checker u_chk (.*);
`default_nettype wire
